// ----- hw/rtl/gerdp_pkg.sv -----
// ----------------------------------------------------------------------------
// gerdp_pkg: shared types and constants of the eight-ray direction picker
// Grid geometry, field widths, input kinds, register indexes, ray step
// functions and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package gerdp_pkg;

	// grid storage geometry
	localparam int MAX_GRID_WIDTH  = 256;
	localparam int MAX_GRID_HEIGHT = 256;
	localparam int COL_W   = $clog2(MAX_GRID_WIDTH);
	localparam int ROW_W   = $clog2(MAX_GRID_HEIGHT);
	localparam int ADDR_W  = COL_W + ROW_W;
	localparam int MEM_DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;

	// field widths
	localparam int DIM_W   = 9;
	localparam int OCC_W   = 8;
	localparam int DIR_W   = 3;
	localparam int SCORE_W = 10;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [DIR_W-1:0] LAST_DIR = 3'd7;

	// input kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	// controller to datapath
	typedef struct packed {
		logic wr;         // store one grid cell from the input transaction
		logic capture;    // latch robot cell of a query
		logic ray_start;  // reset walk position and score to the robot cell
		logic rd;         // read the cell under the walk position
		logic eval;       // score the cell just read
		logic commit;     // compare ray against best, advance direction
		logic emit;       // load the output register
	} gerdp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pos_ok;     // robot cell lies inside the configured grid
		logic ray_done;   // cell read is an obstacle or the ray hits the edge
		logic last_dir;   // current ray is the final one
		logic out_free;   // output register can take a result
	} gerdp_sts_t;

	// column step per ray: 0 up, clockwise to 7 up-left
	function automatic logic signed [1:0] dir_dc(input logic [DIR_W-1:0] dir);
		logic signed [1:0] s;
		unique case (dir)
			3'd0, 3'd4: s = 2'sd0;
			3'd1, 3'd2, 3'd3: s = 2'sd1;
			default: s = -2'sd1;
		endcase
		return s;
	endfunction

	// row step per ray (row grows downward)
	function automatic logic signed [1:0] dir_dr(input logic [DIR_W-1:0] dir);
		logic signed [1:0] s;
		unique case (dir)
			3'd2, 3'd6: s = 2'sd0;
			3'd3, 3'd4, 3'd5: s = 2'sd1;
			default: s = -2'sd1;
		endcase
		return s;
	endfunction

endpackage

// ----- hw/rtl/gerdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// gerdp_ctrl: sequencer of the ray walk
// Takes input transactions while idle, walks the eight rays one cell per
// read/evaluate pair and hands the result to the output register.
// ----------------------------------------------------------------------------
module gerdp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 s_tuser,
	input  gerdp_pkg::gerdp_sts_t sts,
	output gerdp_pkg::gerdp_cmd_t cmd
);
	import gerdp_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_EVAL   = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr      = accept && (s_tuser == KIND_WRITE);
				cmd.capture = accept && (s_tuser == KIND_QUERY);
				if (cmd.capture) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.pos_ok) begin
					cmd.ray_start = 1'b1;
					state_d       = ST_READ;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.ray_done ? ST_COMMIT : ST_READ;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				if (sts.last_dir) begin
					state_d = ST_EMIT;
				end else begin
					cmd.ray_start = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/gerdp_dpath.sv -----
// ----------------------------------------------------------------------------
// gerdp_dpath: grid memory, ray walker and best-ray tracking
// Holds the occupancy grid, the configuration registers, the walk position
// and score of the current ray, the best ray so far and the output register.
// ----------------------------------------------------------------------------
module gerdp_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gerdp_pkg::gerdp_cmd_t                cmd,
	output gerdp_pkg::gerdp_sts_t                sts,
	input  logic [gerdp_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                 cfg_valid,
	input  logic [gerdp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gerdp_pkg::DIM_W-1:0]          cfg_data,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [gerdp_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import gerdp_pkg::*;

	// input fields
	logic [COL_W-1:0] in_col;
	logic [ROW_W-1:0] in_row;
	logic [OCC_W-1:0] in_occ;

	assign in_col = s_tdata[7:0];
	assign in_row = s_tdata[15:8];
	assign in_occ = s_tdata[23:16];

	// configuration registers
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(256);
			height_q <= DIM_W'(256);
		end else if (cfg_valid) begin
			if (cfg_index == REG_GRID_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == REG_GRID_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	assign w_eff = (width_q > DIM_W'(MAX_GRID_WIDTH)) ? DIM_W'(MAX_GRID_WIDTH) : width_q;
	assign h_eff = (height_q > DIM_W'(MAX_GRID_HEIGHT)) ? DIM_W'(MAX_GRID_HEIGHT) : height_q;

	// walk registers
	logic [COL_W-1:0]   rob_c_q;
	logic [ROW_W-1:0]   rob_r_q;
	logic               pos_ok_q;
	logic [DIR_W-1:0]   dir_q;
	logic [COL_W-1:0]   cur_c_q;
	logic [ROW_W-1:0]   cur_r_q;
	logic [SCORE_W-1:0] score_q;
	logic [COL_W-1:0]   tc_q;
	logic [ROW_W-1:0]   tr_q;
	logic               hit_q;
	logic [OCC_W-1:0]   rd_data_q;

	// best ray so far
	logic [DIR_W-1:0]   best_dir_q;
	logic [COL_W-1:0]   best_c_q;
	logic [ROW_W-1:0]   best_r_q;
	logic [SCORE_W-1:0] best_score_q;
	logic               best_hit_q;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// grid storage, no reset: cells must be written before they are queried; the block does not enforce this
	logic [OCC_W-1:0] mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[{in_row, in_col}] <= in_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem[{cur_r_q, cur_c_q}];
		end
	end

	// cell classification and edge detection
	logic               obst;
	logic               unknown;
	logic               edge_c;
	logic               edge_r;
	logic signed [1:0]  dc;
	logic signed [1:0]  dr;
	logic [COL_W-1:0]   nxt_c;
	logic [ROW_W-1:0]   nxt_r;
	logic [SCORE_W-1:0] score_inc;
	logic               robot_in;

	assign unknown = rd_data_q[OCC_W-1];
	assign obst    = !unknown && (rd_data_q > OCC_W'(1));
	assign dc      = dir_dc(dir_q);
	assign dr      = dir_dr(dir_q);
	assign edge_c  = ((dc == -2'sd1) && (cur_c_q == '0)) ||
	                 ((dc == 2'sd1) && ((DIM_W'(cur_c_q) + DIM_W'(1)) == w_eff));
	assign edge_r  = ((dr == -2'sd1) && (cur_r_q == '0)) ||
	                 ((dr == 2'sd1) && ((DIM_W'(cur_r_q) + DIM_W'(1)) == h_eff));
	assign nxt_c   = cur_c_q + COL_W'(dc);
	assign nxt_r   = cur_r_q + ROW_W'(dr);
	assign score_inc = unknown ? SCORE_W'(2) : SCORE_W'(1);
	assign robot_in  = (DIM_W'(in_col) < w_eff) && (DIM_W'(in_row) < h_eff);

	// query capture and walk control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_ok_q <= 1'b0;
			dir_q    <= '0;
		end else begin
			if (cmd.capture) begin
				pos_ok_q <= robot_in;
				dir_q    <= '0;
			end else if (cmd.commit) begin
				dir_q <= dir_q + DIR_W'(1);
			end
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rob_c_q <= in_col;
			rob_r_q <= in_row;
		end
		if (cmd.ray_start) begin
			cur_c_q <= rob_c_q;
			cur_r_q <= rob_r_q;
			score_q <= '0;
			hit_q   <= 1'b0;
		end else if (cmd.eval) begin
			tc_q <= cur_c_q;
			tr_q <= cur_r_q;
			if (obst) begin
				hit_q <= 1'b1;
			end else begin
				score_q <= score_q + score_inc;
				if (!(edge_c || edge_r)) begin
					cur_c_q <= nxt_c;
					cur_r_q <= nxt_r;
				end
			end
		end
	end

	// keep the first ray, then only a strictly higher score
	always_ff @(posedge clk) begin
		if (cmd.commit && ((dir_q == '0) || (score_q > best_score_q))) begin
			best_dir_q   <= dir_q;
			best_c_q     <= tc_q;
			best_r_q     <= tr_q;
			best_score_q <= score_q;
			best_hit_q   <= hit_q;
		end
	end

	// output register: result stays until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (pos_ok_q) begin
				out_data_q <= {1'b0, 1'b1, best_hit_q, best_score_q,
				               best_r_q, best_c_q, best_dir_q};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign sts.pos_ok   = pos_ok_q;
	assign sts.ray_done = obst || edge_c || edge_r;
	assign sts.last_dir = (dir_q == LAST_DIR);
	assign sts.out_free = !out_valid_q || m_tready;

`ifndef SYNTHESIS
	// a cell is only read while the walk stays inside the grid
	a_rd_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (pos_ok_q && (DIM_W'(cur_c_q) < w_eff) && (DIM_W'(cur_r_q) < h_eff)))
		else $error("grid read outside configured grid");

	// a ray never scores more than two per cell of the longest line
	a_score_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (score_q <= SCORE_W'(512)))
		else $error("ray score beyond bound");

	// a loaded result shows up on the output in the next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("emitted result not presented");

	// a result is never loaded over one that waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || m_tready))
		else $error("output register overwritten");
`endif

endmodule

// ----- hw/rtl/grid_eight_ray_direction_pick_top.sv -----
// A robot cell outside the configured grid skips the walk and returns an all-zero result.
// Grid writes are taken one per cycle; a query blocks input until its result is
// loaded into the output register, each walked cell costing one memory read and one evaluation.
// Reset clears control and sets both grid dimensions to 256; grid contents are
// undefined until written and take no clearing pass.
// ----------------------------------------------------------------------------
// grid_eight_ray_direction_pick_top: eight-ray direction picker
// Loads an occupancy grid cell by cell and, per query, returns the ray from
// the robot cell with the highest free/unknown score and its end cell.
// ----------------------------------------------------------------------------
module grid_eight_ray_direction_pick_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [gerdp_pkg::IN_DATA_W-1:0]      s_tdata,  // col[7:0], row[15:8], occupancy[23:16]
	input  logic                                 s_tuser,  // kind
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [gerdp_pkg::OUT_DATA_W-1:0]     m_tdata,  // best_direction[2:0], target_col[10:3],
	                                                       // target_row[18:11], best_score[28:19],
	                                                       // obstacle_hit[29], position_ok[30], zero[31]
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gerdp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gerdp_pkg::DIM_W-1:0]          cfg_data
);
	import gerdp_pkg::*;

	gerdp_cmd_t cmd;
	gerdp_sts_t sts;

	// registers are always writable
	assign cfg_ready = 1'b1;

	gerdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	gerdp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
